[rtl/core/mlfq_pkg.sv]
// shared constants, types and codes of the feedback queue scheduler
`default_nettype none
package mlfq_pkg;

   localparam int THREADS          = 16;
   localparam int LEVELS           = 3;
   localparam int TID_W            = 4;
   localparam int IDX_W            = $clog2(THREADS);
   localparam int CNT_W            = $clog2(THREADS + 1);
   localparam int LVL_W            = 2;
   localparam int BUD_W            = 9;
   localparam int QNT_W            = 8;
   localparam int FUNC_W           = 2;
   localparam int CSR_IDX_W        = 2;
   localparam int PROMO_THRESHOLD  = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_EXIT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = 2'd2;

   localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
   localparam logic [LVL_W-1:0] LVL_MID    = 2'd1;
   localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [TID_W-1:0]  tid;
      logic [LVL_W-1:0]  lvl;
   } entry_type;

   typedef struct packed {
      logic              by_level;
      logic [TID_W-1:0]  key_tid;
      logic [LVL_W-1:0]  key_lvl;
      logic              remove;
      logic              append;
      logic [IDX_W-1:0]  tail;
      entry_type         new_entry;
   } chain_ctl_type;

   typedef struct packed {
      logic              found;
      entry_type         hit_entry;
      logic [LEVELS-1:0] level_busy;
   } chain_stat_type;

endpackage
`default_nettype wire

[rtl/core/mlfq_if.sv]
// request and response channel interfaces
`default_nettype none
interface mlfq_req_if;
   logic                          valid;
   logic                          ready;
   logic [mlfq_pkg::FUNC_W-1:0]   func;
   logic [mlfq_pkg::TID_W-1:0]    thread_id;
   modport source(output valid, output func, output thread_id, input ready);
   modport sink(input valid, input func, input thread_id, output ready);
endinterface

interface mlfq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mlfq_pkg::TID_W-1:0]    picked_thread;
   logic                          picked_valid;
   logic                          reschedule;
   logic                          full_error;
   modport source(output valid, output picked_thread, output picked_valid,
                  output reschedule, output full_error, input ready);
   modport sink(input valid, input picked_thread, input picked_valid,
                input reschedule, input full_error, output ready);
endinterface
`default_nettype wire

[rtl/core/multilevel_feedback_queue_scheduler_top.sv]
// three-level feedback queue scheduler top level
//
//  port group  role     carries
//  req         sink     func, thread_id
//  rsp         source   picked_thread, picked_valid, reschedule, full_error
//  csr_*       write    csr_write_enable, csr_index, csr_write_data
//
// push, pop and exit finish in the accept cycle; the result is registered.
// tick ends in the charge state; a promotion tick first sweeps the mid level
// and then the bottom level, moving one thread at a time back to the top.
// one item at a time; the next is taken once the result register is free.
// synchronous active-high reset empties all queues and clears all budgets.
`default_nettype none
module multilevel_feedback_queue_scheduler_top (
   input  wire                               clock,
   input  wire                               reset,
   mlfq_req_if.sink                          req,
   mlfq_rsp_if.source                        rsp,
   input  wire                               csr_write_enable,
   input  wire [mlfq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [mlfq_pkg::QNT_W-1:0]         csr_write_data
);
   import mlfq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PROMO1 = 4'b0010,
      ST_PROMO2 = 4'b0100,
      ST_CHARGE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [THREADS-1:0]      present_ff, present_in;
   logic signed [BUD_W-1:0] budget_ff [THREADS];
   logic                    run_valid_ff, run_valid_in;
   logic [TID_W-1:0]        run_tid_ff, run_tid_in;
   logic [QNT_W-1:0]        countdown_ff, countdown_in;
   logic [QNT_W-1:0]        quantum0_ff, quantum1_ff, period_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [TID_W-1:0]        out_tid_ff, out_tid_in;
   logic                    out_pvalid_ff, out_pvalid_in;
   logic                    out_resched_ff, out_resched_in;
   logic                    out_full_ff, out_full_in;

   chain_ctl_type           ctl;
   chain_stat_type          stat;

   logic                    accept;
   logic                    full;
   logic [CNT_W-1:0]        count_dec;
   logic                    bud_we;
   logic [TID_W-1:0]        bud_addr;
   logic signed [BUD_W-1:0] bud_wdata;
   logic signed [BUD_W-1:0] bud_run;
   logic signed [BUD_W-1:0] bud_dec;
   logic signed [BUD_W-1:0] load0, load1;

   mlfq_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .stat  (stat)
   );

   assign req.ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign count_dec = count_ff - CNT_W'(1);
   assign full      = (count_ff == CNT_W'(THREADS)) && !stat.level_busy[1] && !stat.level_busy[2];
   assign load0     = signed'({1'b0, quantum0_ff});
   assign load1     = signed'({1'b0, quantum1_ff});
   assign bud_run   = budget_ff[run_tid_ff];
   assign bud_dec   = (bud_run != '1) ? bud_run - BUD_W'(1) : bud_run;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      present_in     = present_ff;
      run_valid_in   = run_valid_ff;
      run_tid_in     = run_tid_ff;
      countdown_in   = countdown_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_tid_in     = out_tid_ff;
      out_pvalid_in  = out_pvalid_ff;
      out_resched_in = out_resched_ff;
      out_full_in    = out_full_ff;
      bud_we         = 1'b0;
      bud_addr       = '0;
      bud_wdata      = '0;
      ctl            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               out_valid_in   = 1'b1;
               out_tid_in     = '0;
               out_pvalid_in  = 1'b0;
               out_resched_in = 1'b0;
               out_full_in    = 1'b0;
               case (req.func)
                  FUNC_PUSH: begin
                     if (full) begin
                        out_full_in = 1'b1;
                     end else if (!present_ff[req.thread_id]) begin
                        present_in[req.thread_id] = 1'b1;
                        ctl.append    = 1'b1;
                        ctl.tail      = count_ff[IDX_W-1:0];
                        ctl.new_entry = '{valid: 1'b1, tid: req.thread_id, lvl: LVL_TOP};
                        count_in      = count_ff + CNT_W'(1);
                        if (budget_ff[req.thread_id] == '0) begin
                           bud_we    = 1'b1;
                           bud_addr  = req.thread_id;
                           bud_wdata = load0;
                        end
                     end
                  end
                  FUNC_POP: begin
                     ctl.by_level = 1'b1;
                     ctl.key_lvl  = stat.level_busy[0] ? LVL_TOP :
                                    stat.level_busy[1] ? LVL_MID : LVL_BOTTOM;
                     if (stat.found) begin
                        ctl.remove    = 1'b1;
                        ctl.append    = 1'b1;
                        ctl.tail      = count_dec[IDX_W-1:0];
                        ctl.new_entry = stat.hit_entry;
                        run_valid_in  = 1'b1;
                        run_tid_in    = stat.hit_entry.tid;
                        out_tid_in    = stat.hit_entry.tid;
                        out_pvalid_in = 1'b1;
                     end
                  end
                  FUNC_TICK: begin
                     out_valid_in = 1'b0;
                     if (countdown_ff <= QNT_W'(1)) begin
                        countdown_in = period_ff;
                        state_in     = ST_PROMO1;
                     end else begin
                        countdown_in = countdown_ff - QNT_W'(1);
                        state_in     = ST_CHARGE;
                     end
                  end
                  FUNC_EXIT: begin
                     ctl.key_tid = req.thread_id;
                     if (run_valid_ff && (run_tid_ff == req.thread_id)) begin
                        ctl.remove = stat.found;
                        if (stat.found) begin
                           count_in = count_dec;
                        end
                        present_in[req.thread_id] = 1'b0;
                        run_valid_in = 1'b0;
                        run_tid_in   = '0;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_PROMO1, ST_PROMO2: begin
            ctl.by_level = 1'b1;
            ctl.key_lvl  = (state_ff == ST_PROMO1) ? LVL_MID : LVL_BOTTOM;
            if (stat.found) begin
               ctl.remove    = 1'b1;
               ctl.append    = 1'b1;
               ctl.tail      = count_dec[IDX_W-1:0];
               ctl.new_entry = '{valid: 1'b1, tid: stat.hit_entry.tid, lvl: LVL_TOP};
               bud_we        = 1'b1;
               bud_addr      = stat.hit_entry.tid;
               bud_wdata     = load0;
            end else begin
               state_in = (state_ff == ST_PROMO1) ? ST_PROMO2 : ST_CHARGE;
            end
         end
         ST_CHARGE: begin
            ctl.key_tid    = run_tid_ff;
            state_in       = ST_IDLE;
            out_valid_in   = 1'b1;
            out_tid_in     = '0;
            out_pvalid_in  = 1'b0;
            out_full_in    = 1'b0;
            out_resched_in = 1'b1;
            if (run_valid_ff) begin
               bud_we    = 1'b1;
               bud_addr  = run_tid_ff;
               bud_wdata = bud_dec;
               if (!bud_dec[BUD_W-1] && (bud_dec != '0)) begin
                  out_resched_in = 1'b0;
               end else if (stat.found && (stat.hit_entry.lvl != LVL_BOTTOM)) begin
                  ctl.remove    = 1'b1;
                  ctl.append    = 1'b1;
                  ctl.tail      = count_dec[IDX_W-1:0];
                  ctl.new_entry = '{valid: 1'b1, tid: run_tid_ff,
                                    lvl: stat.hit_entry.lvl + LVL_W'(1)};
                  bud_wdata     = (stat.hit_entry.lvl == LVL_TOP) ? load0 : load1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         run_valid_ff <= 1'b0;
         run_tid_ff   <= '0;
         countdown_ff <= QNT_W'(PROMO_THRESHOLD);
         quantum0_ff  <= QNT_W'(1);
         quantum1_ff  <= QNT_W'(2);
         period_ff    <= QNT_W'(PROMO_THRESHOLD);
         out_valid_ff <= 1'b0;
         for (int i = 0; i < THREADS; i++) begin
            budget_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         run_valid_ff <= run_valid_in;
         run_tid_ff   <= run_tid_in;
         countdown_ff <= countdown_in;
         out_valid_ff <= out_valid_in;
         if (bud_we) begin
            budget_ff[bud_addr] <= bud_wdata;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_QUANTUM0: quantum0_ff <= csr_write_data;
               CSR_QUANTUM1: quantum1_ff <= csr_write_data;
               CSR_PERIOD:   period_ff   <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_tid_ff     <= out_tid_in;
      out_pvalid_ff  <= out_pvalid_in;
      out_resched_ff <= out_resched_in;
      out_full_ff    <= out_full_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.picked_thread = out_tid_ff;
   assign rsp.picked_valid  = out_pvalid_ff;
   assign rsp.reschedule    = out_resched_ff;
   assign rsp.full_error    = out_full_ff;
endmodule
`default_nettype wire

[rtl/core/mlfq_cell.sv]
// one queue slot of the ordered thread chain
`default_nettype none
module mlfq_cell (
   input  wire                              clock,
   input  wire                              reset,
   input  mlfq_pkg::chain_ctl_type          ctl,
   input  wire [mlfq_pkg::IDX_W-1:0]        cell_index,
   input  mlfq_pkg::entry_type              right_entry,
   input  wire                              seen_in,
   output logic                             seen_out,
   output logic                             hit,
   output mlfq_pkg::entry_type              entry
);
   import mlfq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      key_match;

   always_comb begin
      key_match = ctl.by_level ? (entry_ff.lvl == ctl.key_lvl) : (entry_ff.tid == ctl.key_tid);
      hit       = entry_ff.valid && !seen_in && key_match;
      seen_out  = seen_in || hit;
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.remove && seen_out) begin
         entry_in = right_entry;
      end
      if (ctl.append && (cell_index == ctl.tail)) begin
         entry_in = ctl.new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

[rtl/core/mlfq_chain.sv]
// row of queue slots with search, removal and tail append
`default_nettype none
module mlfq_chain (
   input  wire                        clock,
   input  wire                        reset,
   input  mlfq_pkg::chain_ctl_type    ctl,
   output mlfq_pkg::chain_stat_type   stat
);
   import mlfq_pkg::*;

   entry_type           entries [THREADS];
   entry_type           rights  [THREADS];
   logic [THREADS:0]    seen;
   logic [THREADS-1:0]  hits;

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < THREADS; i++) begin : g_cell
      if (i == THREADS - 1) begin : g_last
         assign rights[i] = '0;
      end else begin : g_mid
         assign rights[i] = entries[i+1];
      end
      mlfq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .cell_index  (IDX_W'(i)),
         .right_entry (rights[i]),
         .seen_in     (seen[i]),
         .seen_out    (seen[i+1]),
         .hit         (hits[i]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      stat = '0;
      stat.found = seen[THREADS];
      for (int i = 0; i < THREADS; i++) begin
         if (hits[i]) begin
            stat.hit_entry = stat.hit_entry | entries[i];
         end
         for (int k = 0; k < LEVELS; k++) begin
            if (entries[i].valid && (entries[i].lvl == LVL_W'(k))) begin
               stat.level_busy[k] = 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire
